[rtl/core/bcg_pkg.sv]
`timescale 1ns / 1ps

package bcg_pkg;

    // phase accumulator width default
    localparam int PHASE_BITS_DEF = 16;

    // channel widths
    localparam int ELAPSED_W  = 16;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_BRIGHTNESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BRIGHTNESS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHTNESS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_A           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_B           = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PHASE     = 3'd7;

    // wave modes
    localparam logic [1:0] MODE_PULSE   = 2'd0;
    localparam logic [1:0] MODE_MORPH   = 2'd1;
    localparam logic [1:0] MODE_RAINBOW = 2'd2;

    // 1.2 Hz in Q4.12
    localparam logic [15:0] FREQ_DEFAULT = 16'd4915;

    typedef struct packed {
        logic [1:0]  wave_mode;
        logic        custom_brightness;
        logic [8:0]  min_brightness;
        logic [8:0]  max_brightness;
        logic [15:0] frequency;
        logic [23:0] color_a;
        logic [23:0] color_b;
        logic [15:0] initial_phase;
    } bcg_cfg_t;

    // cos(k*pi/64) in Q16, k = 0..32
    function automatic logic [16:0] cos_tab(input logic [5:0] idx);
        logic [16:0] v;
        case (idx)
            6'd0:  v = 17'd65536;
            6'd1:  v = 17'd65457;
            6'd2:  v = 17'd65220;
            6'd3:  v = 17'd64827;
            6'd4:  v = 17'd64277;
            6'd5:  v = 17'd63572;
            6'd6:  v = 17'd62714;
            6'd7:  v = 17'd61705;
            6'd8:  v = 17'd60547;
            6'd9:  v = 17'd59244;
            6'd10: v = 17'd57798;
            6'd11: v = 17'd56212;
            6'd12: v = 17'd54491;
            6'd13: v = 17'd52639;
            6'd14: v = 17'd50660;
            6'd15: v = 17'd48559;
            6'd16: v = 17'd46341;
            6'd17: v = 17'd44011;
            6'd18: v = 17'd41576;
            6'd19: v = 17'd39040;
            6'd20: v = 17'd36410;
            6'd21: v = 17'd33692;
            6'd22: v = 17'd30893;
            6'd23: v = 17'd28020;
            6'd24: v = 17'd25080;
            6'd25: v = 17'd22078;
            6'd26: v = 17'd19024;
            6'd27: v = 17'd15924;
            6'd28: v = 17'd12785;
            6'd29: v = 17'd9616;
            6'd30: v = 17'd6424;
            6'd31: v = 17'd3216;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/bcg_if.sv]
`timescale 1ns / 1ps

// timer request channel
interface bcg_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] elapsed;

    modport source (output valid, output opcode, output elapsed, input ready);
    modport sink (input valid, input opcode, input elapsed, output ready);
endinterface

// color result channel
interface bcg_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// register write channel
interface bcg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/bcg_mul.sv]
`timescale 1ns / 1ps

module bcg_mul (
    input  logic                                clk,
    input  logic signed [bcg_pkg::MUL_A_W-1:0] a,
    input  logic signed [bcg_pkg::MUL_B_W-1:0] b,
    output logic signed [bcg_pkg::MUL_P_W-1:0] p
);
    import bcg_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;
    logic signed [MUL_P_W-1:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

[rtl/core/bcg_seq.sv]
`timescale 1ns / 1ps

module bcg_seq #(
    parameter int PHASE_BITS = bcg_pkg::PHASE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    bcg_req_if.sink                             req,
    bcg_rgb_if.source                           rsp,
    input  bcg_pkg::bcg_cfg_t                   cfg_regs,
    output logic signed [bcg_pkg::MUL_A_W-1:0] mul_a,
    output logic signed [bcg_pkg::MUL_B_W-1:0] mul_b,
    input  logic signed [bcg_pkg::MUL_P_W-1:0] mul_p
);
    import bcg_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_INC    = 4'd1;
    localparam logic [3:0] ST_ACC    = 4'd2;
    localparam logic [3:0] ST_PHASE  = 4'd3;
    localparam logic [3:0] ST_COS    = 4'd4;
    localparam logic [3:0] ST_WAVE   = 4'd5;
    localparam logic [3:0] ST_SWING  = 4'd6;
    localparam logic [3:0] ST_BRIGHT = 4'd7;
    localparam logic [3:0] ST_CHAN   = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    localparam logic [1:0] PASS_SCALE_A   = 2'd0;
    localparam logic [1:0] PASS_SCALE_RGB = 2'd1;
    localparam logic [1:0] PASS_MORPH     = 2'd2;
    localparam logic [1:0] PASS_HUE       = 2'd3;

    localparam logic [1:0] CNT_LAST = 2'd3;

    function automatic logic [7:0] chan_of(input logic [23:0] c, input logic [1:0] k);
        logic [7:0] v;
        case (k)
            2'd0:    v = c[7:0];
            2'd1:    v = c[15:8];
            default: v = c[23:16];
        endcase
        return v;
    endfunction

    logic [3:0]            state_reg, state_next;
    logic                  opcode_reg, opcode_next;
    logic [15:0]           elapsed_reg, elapsed_next;
    logic [PHASE_BITS-1:0] accum_reg, accum_next;
    logic [15:0]           phase_reg, phase_next;
    logic [16:0]           wave_reg, wave_next;
    logic [24:0]           bq_reg, bq_next;
    logic [16:0]           lvl_reg [3];
    logic [16:0]           lvl_next [3];
    logic [7:0]            rgb_reg [3];
    logic [7:0]            rgb_next [3];
    logic [1:0]            pass_reg, pass_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [7:0]            red_reg, red_next;
    logic [7:0]            green_reg, green_next;
    logic [7:0]            blue_reg, blue_next;

    // phase advance
    logic [15:0]              freq_eff;
    logic [63:0]              inc_ext;
    logic [PHASE_BITS-1:0]    inc;
    logic [PHASE_BITS+15:0]   top_ext;
    logic [15:0]              top16;

    assign freq_eff = (cfg_regs.frequency == 16'd0) ? FREQ_DEFAULT : cfg_regs.frequency;
    assign inc_ext  = {mul_p[31:0], 32'd0} >> (60 - PHASE_BITS);
    assign inc      = inc_ext[PHASE_BITS-1:0];
    assign top_ext  = {accum_reg, 16'd0};
    assign top16    = top_ext[PHASE_BITS +: 16];

    // quarter-wave cosine lookup
    logic [1:0]  quad;
    logic [14:0] xx;
    logic        cos_zero;
    logic [4:0]  seg;
    logic [8:0]  frac;
    logic [16:0] cos_lo;
    logic [16:0] cos_hi;
    logic [16:0] cos_d;
    logic [21:0] interp_sum;
    logic [16:0] qc;
    logic [17:0] wsum;

    assign quad       = phase_reg[15:14];
    assign xx         = quad[0] ? (15'd16384 - {1'b0, phase_reg[13:0]})
                                : {1'b0, phase_reg[13:0]};
    assign cos_zero   = xx[14];
    assign seg        = xx[13:9];
    assign frac       = xx[8:0];
    assign cos_lo     = cos_tab({1'b0, seg});
    assign cos_hi     = cos_tab({1'b0, seg} + 6'd1);
    assign cos_d      = cos_lo - cos_hi;
    assign interp_sum = mul_p[21:0] + 22'd256;
    assign qc         = cos_zero ? 17'd0 : (cos_lo - {4'd0, interp_sum[21:9]});
    assign wsum       = (quad[1] ^ quad[0]) ? (18'd65536 - {1'b0, qc})
                                            : (18'd65536 + {1'b0, qc});

    // brightness swing
    logic signed [9:0]  br_diff;
    logic signed [27:0] sw;
    logic [24:0]        bq_val;

    assign br_diff = $signed({1'b0, cfg_regs.max_brightness})
                   - $signed({1'b0, cfg_regs.min_brightness});
    assign sw      = $signed({3'd0, cfg_regs.min_brightness, 16'd0}) + $signed(mul_p[27:0]);

    always_comb
    begin
        if (sw[27])
            bq_val = 25'd0;
        else if (sw > 28'sd16777216)
            bq_val = 25'h1000000;
        else
            bq_val = sw[24:0];
    end

    // hue levels
    logic [18:0] p6;
    logic [2:0]  sector;
    logic [16:0] hx;
    logic [16:0] lvl_r, lvl_g, lvl_b;

    assign p6     = {1'b0, phase_reg, 2'b00} + {2'b00, phase_reg, 1'b0};
    assign sector = p6[18:16];
    assign hx     = sector[0] ? (17'd65536 - {1'b0, p6[15:0]}) : {1'b0, p6[15:0]};

    always_comb
    begin
        case (sector)
            3'd0:    begin lvl_r = 17'd65536; lvl_g = hx;        lvl_b = 17'd0;     end
            3'd1:    begin lvl_r = hx;        lvl_g = 17'd65536; lvl_b = 17'd0;     end
            3'd2:    begin lvl_r = 17'd0;     lvl_g = 17'd65536; lvl_b = hx;        end
            3'd3:    begin lvl_r = 17'd0;     lvl_g = hx;        lvl_b = 17'd65536; end
            3'd4:    begin lvl_r = hx;        lvl_g = 17'd0;     lvl_b = 17'd65536; end
            default: begin lvl_r = 17'd65536; lvl_g = 17'd0;     lvl_b = hx;        end
        endcase
    end

    // channel pass: issue for cnt, capture for cnt - 1
    logic [1:0]         ci;
    logic [1:0]         ki;
    logic [7:0]         a_iss, b_iss;
    logic signed [8:0]  morph_d;
    logic [7:0]         a_cap;
    logic [33:0]        sc_sum;
    logic [9:0]         sc_q;
    logic signed [26:0] mv;
    logic signed [10:0] mq;
    logic [49:0]        h_sum;
    logic [9:0]         h_q;
    logic [7:0]         cap_val;

    assign ci      = cnt_reg;
    assign ki      = cnt_reg - 2'd1;
    assign a_iss   = chan_of(cfg_regs.color_a, ci);
    assign b_iss   = chan_of(cfg_regs.color_b, ci);
    assign morph_d = $signed({1'b0, b_iss}) - $signed({1'b0, a_iss});
    assign a_cap   = chan_of(cfg_regs.color_a, ki);
    assign sc_sum  = mul_p[33:0] + 34'h0_0080_0000;
    assign sc_q    = sc_sum[33:24];
    assign mv      = $signed({3'd0, a_cap, 16'd0}) + $signed(mul_p[26:0]) + 27'sd32768;
    assign mq      = mv[26:16];
    assign h_sum   = {1'b0, mul_p[40:0], 8'd0} - {9'd0, mul_p[40:0]} + (50'd1 << 39);
    assign h_q     = h_sum[49:40];

    always_comb
    begin
        case (pass_reg)
            PASS_MORPH:
            begin
                if (mq[10])
                    cap_val = 8'd0;
                else if (mq > 11'sd255)
                    cap_val = 8'd255;
                else
                    cap_val = mq[7:0];
            end
            PASS_HUE:
                cap_val = (h_q > 10'd255) ? 8'd255 : h_q[7:0];
            default:
                cap_val = (sc_q > 10'd255) ? 8'd255 : sc_q[7:0];
        endcase
    end

    // multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_INC:
            begin
                mul_a = {10'd0, elapsed_reg};
                mul_b = {2'd0, freq_eff};
            end
            ST_COS:
            begin
                mul_a = {9'd0, cos_d};
                mul_b = {9'd0, frac};
            end
            ST_SWING:
            begin
                mul_a = {{16{br_diff[9]}}, br_diff};
                mul_b = {1'b0, wave_reg};
            end
            ST_CHAN:
            begin
                case (pass_reg)
                    PASS_SCALE_A:
                    begin
                        mul_a = {1'b0, bq_reg};
                        mul_b = {10'd0, a_iss};
                    end
                    PASS_SCALE_RGB:
                    begin
                        mul_a = {1'b0, bq_reg};
                        mul_b = {10'd0, rgb_reg[ci]};
                    end
                    PASS_MORPH:
                    begin
                        mul_a = {{17{morph_d[8]}}, morph_d};
                        mul_b = {1'b0, wave_reg};
                    end
                    default:
                    begin
                        mul_a = cfg_regs.custom_brightness ? {1'b0, bq_reg} : 26'h1000000;
                        mul_b = {1'b0, lvl_reg[ci]};
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        opcode_next    = opcode_reg;
        elapsed_next   = elapsed_reg;
        accum_next     = accum_reg;
        phase_next     = phase_reg;
        wave_next      = wave_reg;
        bq_next        = bq_reg;
        lvl_next       = lvl_reg;
        rgb_next       = rgb_reg;
        pass_next      = pass_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;

        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    opcode_next  = req.opcode;
                    elapsed_next = req.elapsed;
                    state_next   = ST_INC;
                end
            end
            ST_INC:
                state_next = ST_ACC;
            ST_ACC:
            begin
                accum_next = opcode_reg ? '0 : (accum_reg + inc);
                state_next = ST_PHASE;
            end
            ST_PHASE:
            begin
                phase_next = cfg_regs.initial_phase + top16;
                state_next = ST_COS;
            end
            ST_COS:
                state_next = ST_WAVE;
            ST_WAVE:
            begin
                wave_next  = wsum[17:1];
                state_next = ST_SWING;
            end
            ST_SWING:
                state_next = ST_BRIGHT;
            ST_BRIGHT:
            begin
                bq_next     = bq_val;
                lvl_next[0] = lvl_r;
                lvl_next[1] = lvl_g;
                lvl_next[2] = lvl_b;
                cnt_next    = 2'd0;
                case (cfg_regs.wave_mode)
                    MODE_RAINBOW: pass_next = PASS_HUE;
                    MODE_MORPH:   pass_next = PASS_MORPH;
                    default:      pass_next = PASS_SCALE_A;
                endcase
                state_next = ST_CHAN;
            end
            ST_CHAN:
            begin
                if (cnt_reg != 2'd0)
                    rgb_next[ki] = cap_val;
                if (cnt_reg == CNT_LAST)
                begin
                    // morph with custom brightness runs a second scaling pass
                    if (pass_reg == PASS_MORPH && cfg_regs.custom_brightness)
                    begin
                        pass_next = PASS_SCALE_RGB;
                        cnt_next  = 2'd0;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            ST_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    red_next       = rgb_reg[0];
                    green_next     = rgb_reg[1];
                    blue_next      = rgb_reg[2];
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            accum_reg     <= '0;
            pass_reg      <= PASS_SCALE_A;
            cnt_reg       <= 2'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            accum_reg     <= accum_next;
            pass_reg      <= pass_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opcode_reg  <= opcode_next;
        elapsed_reg <= elapsed_next;
        phase_reg   <= phase_next;
        wave_reg    <= wave_next;
        bq_reg      <= bq_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
        for (int i = 0; i < 3; i++)
        begin
            lvl_reg[i] <= lvl_next[i];
            rgb_reg[i] <= rgb_next[i];
        end
    end

    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.red   = red_reg;
    assign rsp.green = green_reg;
    assign rsp.blue  = blue_reg;

endmodule

[rtl/core/breathing_color_generator.sv]
`timescale 1ns / 1ps

// breathing color generator: each request on req either restarts the phase
// timer (opcode 1) or advances it by elapsed * frequency turns (opcode 0), and
// yields exactly one color on rsp. every multiply runs through a single shared
// 26x18 signed multiplier with a registered product, stepped by a small
// sequencer, so the block takes one request at a time. a request steps
// through the inc, acc, phase, cos, wave, swing and bright states, a
// three-channel pass through the multiplier in the chan state and the out
// state, with a second chan pass in two-color morph mode with
// custom_brightness set. a finished color sits in an output register, so the
// next request is accepted while it waits; only a new color meeting an
// untaken one stalls the sequencer. registers are written through cfg, which
// is always ready; write them only while no request is in flight
module breathing_color_generator #(
    parameter int PHASE_BITS = bcg_pkg::PHASE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bcg_req_if.sink   req,
    bcg_rgb_if.source rsp,
    bcg_cfg_if.sink   cfg
);
    import bcg_pkg::*;

    // register bank
    bcg_cfg_t cfg_reg;
    bcg_cfg_t cfg_next;

    // shared multiplier hookup
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    // writes are never back-pressured
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_WAVE_MODE:         cfg_next.wave_mode         = cfg.data[1:0];
                REG_CUSTOM_BRIGHTNESS: cfg_next.custom_brightness = cfg.data[0];
                REG_MIN_BRIGHTNESS:    cfg_next.min_brightness    = cfg.data[8:0];
                REG_MAX_BRIGHTNESS:    cfg_next.max_brightness    = cfg.data[8:0];
                REG_FREQUENCY:         cfg_next.frequency         = cfg.data[15:0];
                REG_COLOR_A:           cfg_next.color_a           = cfg.data;
                REG_COLOR_B:           cfg_next.color_b           = cfg.data;
                REG_INITIAL_PHASE:     cfg_next.initial_phase     = cfg.data[15:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // reset values: pulse mode, full swing, 1.2 Hz, white
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wave_mode         <= MODE_PULSE;
            cfg_reg.custom_brightness <= 1'b0;
            cfg_reg.min_brightness    <= 9'd0;
            cfg_reg.max_brightness    <= 9'd256;
            cfg_reg.frequency         <= FREQ_DEFAULT;
            cfg_reg.color_a           <= 24'hFFFFFF;
            cfg_reg.color_b           <= 24'h000000;
            cfg_reg.initial_phase     <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // sequencer with phase accumulator, wave, brightness and channel passes
    bcg_seq #(
        .PHASE_BITS(PHASE_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg_regs (cfg_reg),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_p    (mul_p)
    );

    // one product per cycle, result registered and ready in the cycle after the operands
    bcg_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

endmodule

[rtl/core/bcg_checker.sv]
`timescale 1ns / 1ps

module bcg_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue
);

    logic req_fire;

    assign req_fire = req_valid && req_ready;

    // block stays busy after taking a request
    assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready)
        else $error("request accepted while busy");

    // a fresh color must follow an accepted request, at the plain lag or at the lag with a second morph pass
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> ($past(req_fire, 13) || $past(req_fire, 17)))
        else $error("color without matching request latency");

    // an untaken color stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("color dropped before taken");

    // an untaken color holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(red) && $stable(green) && $stable(blue))
        else $error("color changed while stalled");

endmodule

bind breathing_color_generator bcg_checker u_bcg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .red       (rsp.red),
    .green     (rsp.green),
    .blue      (rsp.blue)
);
